>>> src/sample_covariance_accumulator_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sample covariance accumulator.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_COVARIANCE_ACCUMULATOR_TOP_ASSERT_SVH
`define SAMPLE_COVARIANCE_ACCUMULATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCOV_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SCOV_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/scov_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scov_pkg
// Shared constants, command codes and the chain token for the accumulator.
// ----------------------------------------------------------------------------
package scov_pkg;

    localparam int MAX_BINS     = 16;
    localparam int MAX_VARIANTS = 256;

    localparam int BIN_W   = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int POS_W   = $clog2(MAX_BINS + 1);
    localparam int VC_W    = $clog2(MAX_VARIANTS + 1);
    localparam int CFG_W   = 5;
    localparam int VAL_W   = 24;
    localparam int DELTA_W = 25;
    localparam int PROD_W  = 2 * DELTA_W;
    localparam int SUM_W   = 58;
    localparam int CNT_W   = $clog2(SUM_W + 1);
    localparam int ADDR_W  = 3;

    typedef enum logic [1:0] {
        CMD_NOMINAL = 2'd0,
        CMD_VARIANT = 2'd1,
        CMD_READ    = 2'd2,
        CMD_CLEAR   = 2'd3
    } t_cmd;

    localparam logic REG_BINS_IN_USE = 1'b0;

    // Token handed from cell to cell. For an accumulate token p is the bin
    // position and d its delta; for a read token p is the lower matrix
    // index, hi the upper one and v carries the picked sum.
    typedef struct packed {
        logic                      vld;
        logic                      rd;
        logic [BIN_W-1:0]          p;
        logic [BIN_W-1:0]          hi;
        logic signed [DELTA_W-1:0] d;
        logic signed [SUM_W-1:0]   v;
    } t_tok;

endpackage

>>> src/scov_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scov_cell
// One cell of the chain: holds one delta and one column of the upper triangle.
// ----------------------------------------------------------------------------
module scov_cell
    import scov_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [BIN_W-1:0] i_pos,
    input  logic             i_clr,
    input  t_tok             i_tok,
    output t_tok             o_tok
);

    logic signed [DELTA_W-1:0] r_delta;
    logic signed [SUM_W-1:0]   r_sum [MAX_BINS];
    t_tok                      r_tok;
    t_tok                      n_tok;

    logic                      acc_en;
    logic                      own;
    logic signed [DELTA_W-1:0] weight;
    logic signed [PROD_W-1:0]  prod;
    logic signed [SUM_W:0]     sum_ext;
    logic signed [SUM_W-1:0]   sum_sat;

    // The token's own bin pairs its delta with itself.
    assign own    = (i_pos == i_tok.p);
    assign acc_en = i_tok.vld && !i_tok.rd && (i_pos <= i_tok.p);
    assign weight = own ? i_tok.d : r_delta;
    assign prod   = weight * i_tok.d;
    assign sum_ext = (SUM_W + 1)'(r_sum[i_tok.p]) + (SUM_W + 1)'(prod);

    // Saturate at the signed limits of the sum.
    always_comb begin
        if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
            sum_sat = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            sum_sat = sum_ext[SUM_W-1:0];
        end
    end

    // A read token picks up this cell's sum when this cell is its lower index.
    always_comb begin
        n_tok = i_tok;
        if (i_tok.vld && i_tok.rd && own) begin
            n_tok.v = r_sum[i_tok.hi];
        end
    end

    // Column of sums, cleared by reset or by the clear command.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            for (int k = 0; k < MAX_BINS; k++) begin
                r_sum[k] <= '0;
            end
        end else if (acc_en) begin
            r_sum[i_tok.p] <= sum_sat;
        end
    end

    // Delta of this bin for the current variant.
    always_ff @(posedge i_clk) begin
        if (acc_en && own) begin
            r_delta <= i_tok.d;
        end
    end

    // Forward the token to the next cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else begin
            r_tok.vld <= n_tok.vld;
        end
        r_tok.rd <= n_tok.rd;
        r_tok.p  <= n_tok.p;
        r_tok.hi <= n_tok.hi;
        r_tok.d  <= n_tok.d;
        r_tok.v  <= n_tok.v;
    end

    assign o_tok = r_tok;

endmodule

>>> src/scov_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scov_div
// Bit-serial signed divider, one quotient bit a cycle, truncating to zero.
// ----------------------------------------------------------------------------
module scov_div
    import scov_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [SUM_W-1:0] i_num,
    input  logic [VC_W-1:0]         i_den,
    output logic                    o_done,
    output logic signed [SUM_W-1:0] o_quo
);

    logic [SUM_W-1:0] r_mag;
    logic [VC_W-1:0]  r_rem;
    logic [VC_W-1:0]  r_den;
    logic             r_neg;
    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;

    logic [VC_W:0]    trial;
    logic             qbit;
    logic [SUM_W-1:0] n_mag;

    // One restoring step on the magnitude. The remainder stays below the
    // divisor, so it always fits in the divisor's width.
    assign trial = {r_rem, r_mag[SUM_W-1]};
    assign qbit  = (trial >= {1'b0, r_den});
    assign n_mag = {r_mag[SUM_W-2:0], qbit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_neg  <= i_num[SUM_W-1];
                r_mag  <= i_num[SUM_W-1] ? SUM_W'(-i_num) : SUM_W'(i_num);
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_mag <= n_mag;
                r_rem <= qbit ? VC_W'(trial - {1'b0, r_den}) : trial[VC_W-1:0];
                if (r_cnt == CNT_W'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                    o_quo  <= r_neg ? -$signed(n_mag) : $signed(n_mag);
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

endmodule

>>> src/sample_covariance_accumulator_top.sv
// Nominal and variant bins are taken one a cycle while no read is running; a
// variant bin runs down the cell chain, overlapping with the bins that follow
// it. A read or clear waits until the chain is empty.
// A read gives one entry per column; each runs down the chain, then through the
// divider when there are two or more variants, and then waits for the output.
// Synchronous active-low reset clears sums, counters and bins_in_use to 16.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_covariance_accumulator_top
// Sample covariance of variant histograms about a nominal histogram.
// ----------------------------------------------------------------------------
`include "sample_covariance_accumulator_top_assert.svh"

module sample_covariance_accumulator_top
    import scov_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [1:0]              i_command,
    input  logic signed [VAL_W-1:0] i_bin_value,
    input  logic [BIN_W-1:0]        i_row_index,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [SUM_W-1:0] o_cov_value,
    output logic [BIN_W-1:0]        o_column_index,
    output logic                    o_last_in_row,
    output logic [VC_W-1:0]         o_variants_used
);

    typedef enum logic [2:0] {S_IDLE, S_ISSUE, S_WAIT, S_DIV, S_OUT} t_state;

    t_state                  r_state;
    logic [CFG_W-1:0]        r_bins;
    logic signed [VAL_W-1:0] r_nom [MAX_BINS];
    logic [POS_W-1:0]        r_npos;
    logic [POS_W-1:0]        r_vpos;
    logic [VC_W-1:0]         r_vc;
    logic [BIN_W-1:0]        r_row;
    logic [BIN_W-1:0]        r_col;
    logic                    r_oval;
    logic signed [SUM_W-1:0] r_cov;

    logic [POS_W-1:0]        nb;
    logic [POS_W-1:0]        np_use;
    logic [POS_W-1:0]        vp_use;
    logic                    in_acc;
    logic                    rc_cmd;
    logic                    chain_busy;
    logic                    var_go;
    logic                    clr;
    logic                    last_col;
    logic                    row_done;
    logic                    div_start;
    logic                    div_done;
    logic signed [SUM_W-1:0] div_quo;
    t_tok                    head_tok;
    t_tok                    w_tok [MAX_BINS+1];

    // Configuration port.
    assign pready = 1'b1;
    assign prdata = 32'(r_bins);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bins <= CFG_W'(16);
        end else if (psel && penable && pwrite && paddr[2] == REG_BINS_IN_USE) begin
            r_bins <= pwdata[CFG_W-1:0];
        end
    end

    // Bins in use, clamped to the supported range.
    always_comb begin
        if (r_bins == '0) begin
            nb = POS_W'(1);
        end else if (int'(r_bins) > MAX_BINS) begin
            nb = POS_W'(MAX_BINS);
        end else begin
            nb = POS_W'(r_bins);
        end
    end

    assign np_use = (r_npos >= nb) ? '0 : r_npos;
    assign vp_use = (r_vpos >= nb) ? '0 : r_vpos;

    // Reads and clears wait for every token to leave the chain.
    always_comb begin
        chain_busy = 1'b0;
        for (int k = 1; k <= MAX_BINS; k++) begin
            chain_busy = chain_busy | w_tok[k].vld;
        end
    end

    assign rc_cmd  = (i_command == CMD_READ) || (i_command == CMD_CLEAR);
    assign o_stall = (r_state != S_IDLE) || (rc_cmd && chain_busy);
    assign in_acc  = i_valid && !o_stall;
    assign var_go  = in_acc && i_command == CMD_VARIANT && r_vc < VC_W'(MAX_VARIANTS);
    assign clr     = in_acc && i_command == CMD_CLEAR;
    assign last_col = ({1'b0, r_col} + 1'b1) == nb;

    // Token entering the chain: a variant bin or a read of one entry.
    always_comb begin
        head_tok.vld = 1'b0;
        head_tok.rd  = 1'b0;
        head_tok.p   = vp_use[BIN_W-1:0];
        head_tok.hi  = '0;
        head_tok.d   = DELTA_W'(i_bin_value) - DELTA_W'(r_nom[vp_use[BIN_W-1:0]]);
        head_tok.v   = '0;
        if (var_go) begin
            head_tok.vld = 1'b1;
        end else if (r_state == S_ISSUE) begin
            head_tok.vld = 1'b1;
            head_tok.rd  = 1'b1;
            head_tok.p   = (r_row < r_col) ? r_row : r_col;
            head_tok.hi  = (r_row < r_col) ? r_col : r_row;
        end
    end

    assign w_tok[0] = head_tok;

    // Chain of cells, one per bin.
    for (genvar k = 0; k < MAX_BINS; k++) begin : g_cell
        scov_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_pos   (BIN_W'(k)),
            .i_clr   (clr),
            .i_tok   (w_tok[k]),
            .o_tok   (w_tok[k+1])
        );
    end

    assign div_start = (r_state == S_WAIT) && w_tok[MAX_BINS].vld && w_tok[MAX_BINS].rd &&
                       (r_vc > VC_W'(1));

    scov_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (w_tok[MAX_BINS].v),
        .i_den   (r_vc - 1'b1),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Nominal store.
    always_ff @(posedge i_clk) begin
        if (in_acc && i_command == CMD_NOMINAL) begin
            r_nom[np_use[BIN_W-1:0]] <= i_bin_value;
        end
    end

    // Command handling and the read sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_npos  <= '0;
            r_vpos  <= '0;
            r_vc    <= '0;
            r_oval  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (i_command)
                            CMD_NOMINAL: begin
                                r_npos <= ((np_use + 1'b1) >= nb) ? '0 : np_use + 1'b1;
                            end
                            CMD_VARIANT: begin
                                if (var_go) begin
                                    if ((vp_use + 1'b1) >= nb) begin
                                        r_vpos <= '0;
                                        r_vc   <= r_vc + 1'b1;
                                    end else begin
                                        r_vpos <= vp_use + 1'b1;
                                    end
                                end
                            end
                            CMD_READ: begin
                                if ({1'b0, i_row_index} < nb) begin
                                    r_row   <= i_row_index;
                                    r_col   <= '0;
                                    r_state <= S_ISSUE;
                                end
                            end
                            CMD_CLEAR: begin
                                r_npos <= '0;
                                r_vpos <= '0;
                                r_vc   <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_ISSUE: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (w_tok[MAX_BINS].vld && w_tok[MAX_BINS].rd) begin
                        if (r_vc > VC_W'(1)) begin
                            r_state <= S_DIV;
                        end else begin
                            r_cov   <= '0;
                            r_oval  <= 1'b1;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_cov   <= div_quo;
                        r_oval  <= 1'b1;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_oval <= 1'b0;
                        if (last_col) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_col   <= r_col + 1'b1;
                            r_state <= S_ISSUE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid         = r_oval;
    assign o_cov_value     = r_cov;
    assign o_column_index  = r_col;
    assign o_last_in_row   = last_col;
    assign o_variants_used = r_vc;

    assign row_done = o_valid && !i_stall && o_last_in_row;

    // A result is only shown in the output state.
    `SCOV_ASSERT_IMP(a_valid_in_out, i_clk, i_rst_n, o_valid, r_state == S_OUT, "stray valid")
    // A read or clear never overlaps tokens still in the chain.
    `SCOV_ASSERT_IMP(a_chain_empty, i_clk, i_rst_n, in_acc && rc_cmd, !chain_busy, "chain busy")
    // The last entry of a row returns the sequencer to idle.
    `SCOV_ASSERT_NXT(a_row_end, i_clk, i_rst_n, row_done, r_state == S_IDLE && !o_valid, "row end")

endmodule
